@@ hdl/mnlc_pkg.sv @@
package mnlc_pkg;

    // Event codes
    localparam logic [3:0] CODE_NOTE_ON  = 4'd9;
    localparam logic [3:0] CODE_NOTE_OFF = 4'd8;

    // Mapped note range
    localparam logic [6:0] NOTE_LOW  = 7'd21;
    localparam logic [6:0] NOTE_HIGH = 7'd108;

    // Pipeline depth
    localparam int         NSTG = 6;

    // Palette geometry
    localparam int         PAL_DEPTH  = 7;
    localparam int         PAL_AW     = $clog2(PAL_DEPTH);
    localparam int         COLOR_W    = 24;
    localparam logic [PAL_AW-1:0] PAL_LAST = PAL_AW'(PAL_DEPTH - 1);

    // Segment boundaries on d = note - 21: (d*6)/87 >= j  <=>  d >= ceil(87*j/6)
    localparam logic [6:0] SEG_B1 = 7'd15;
    localparam logic [6:0] SEG_B2 = 7'd29;
    localparam logic [6:0] SEG_B3 = 7'd44;
    localparam logic [6:0] SEG_B4 = 7'd58;
    localparam logic [6:0] SEG_B5 = 7'd73;
    localparam logic [6:0] SEG_B6 = 7'd87;

    // Reciprocals for constant division (exact over the value ranges used)
    localparam logic [7:0]  RECIP_14  = 8'd147;    // d/14   = (d*147) >> 11, d < 88
    localparam logic [11:0] RECIP_7   = 12'd2341;  // x/7    = (x*2341) >> 14, x < 1786
    localparam logic [15:0] RECIP_127 = 16'd33027; // x/127  = (x*33027) >> 22, x < 32768
    localparam logic [16:0] RECIP_255 = 17'd65794; // x/255  = (x*65794) >> 24, x < 65026
    localparam logic [3:0]  SEG_LEN   = 4'd14;

    // Register reset values
    localparam logic [7:0] MIN_BRIGHT_RESET = 8'd20;
    localparam logic [PAL_DEPTH-1:0][COLOR_W-1:0] PAL_RESET = {
        24'h9400D3, 24'h4B0082, 24'h0000FF, 24'h00FF00,
        24'hFFFF00, 24'hFF7F00, 24'hFF0000
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_BRIGHT = 3'd0,
        CFG_PAL_0      = 3'd1,
        CFG_PAL_1      = 3'd2,
        CFG_PAL_2      = 3'd3,
        CFG_PAL_3      = 3'd4,
        CFG_PAL_4      = 3'd5,
        CFG_PAL_5      = 3'd6,
        CFG_PAL_6      = 3'd7
    } t_cfg_idx;

    // Beat payloads
    typedef struct packed {
        logic [3:0] code_index;
        logic [6:0] note_number;
        logic [6:0] note_velocity;
    } t_in;

    typedef struct packed {
        logic       led_action;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_out;

    // Stage load enables for the per-channel datapath
    typedef struct packed {
        logic ld_mix;
        logic ld_div;
        logic ld_scale;
        logic ld_out;
    } t_chan_ctl;

endpackage

@@ hdl/mnlc_ram.sv @@
module mnlc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

@@ hdl/mnlc_chan.sv @@
module mnlc_chan (
    input  logic                 i_clk,
    input  mnlc_pkg::t_chan_ctl  i_ctl,
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic [3:0]           i_k,
    input  logic [7:0]           i_bright,
    output logic [7:0]           o_level
);
    import mnlc_pkg::*;

    logic [11:0] r_sum;
    logic [7:0]  r_chan;
    logic [15:0] r_prod;
    logic [7:0]  r_level;

    logic [11:0] n_sum;
    logic [22:0] n_div7;
    logic [15:0] n_prod;
    logic [32:0] n_div255;

    // Blend two palette bytes: a*(14-k) + b*k
    assign n_sum = 12'(i_a) * 12'(SEG_LEN - i_k) + 12'(i_b) * 12'(i_k);

    // sum/14 = (sum/2)/7
    assign n_div7 = 23'(r_sum[11:1]) * 23'(RECIP_7);

    // Scale by brightness
    assign n_prod = 16'(r_chan) * 16'(i_bright);

    // prod/255
    assign n_div255 = 33'(r_prod) * 33'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mix) begin
            r_sum <= n_sum;
        end
        if (i_ctl.ld_div) begin
            r_chan <= n_div7[21:14];
        end
        if (i_ctl.ld_scale) begin
            r_prod <= n_prod;
        end
        if (i_ctl.ld_out) begin
            r_level <= n_div255[31:24];
        end
    end

    assign o_level = r_level;

endmodule

@@ hdl/midi_note_to_led_color.sv @@
// Throughput: one beat per cycle while the receiver does not stall. Six register stages,
// each with its own valid bit; a stage loads when it is empty or the one after it loads.
// Beats with a code other than note-on or note-off are consumed with no result.
// Reset (synchronous, active low) empties the pipeline and restores min brightness
// and the seven palette colors to their defaults; the palette RAM needs no clearing pass.
module midi_note_to_led_color (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mnlc_pkg::t_in      i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output mnlc_pkg::t_out     o_data,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_wdata
);
    import mnlc_pkg::*;

    // Pipeline control
    logic [NSTG:1] r_v;
    logic [NSTG:1] rdy;

    // Configuration
    logic [7:0]           r_min_bright;
    logic [PAL_DEPTH-1:0] r_pal_wr;
    logic                 pal_we;
    logic [PAL_AW-1:0]    pal_waddr;

    // Stage 1
    logic [6:0]  r1_d;
    logic [2:0]  r1_s;
    logic [2:0]  r1_q14;
    logic [14:0] r1_bprod;
    logic        r1_clear;
    logic        r1_inrange;
    logic [6:0]  n1_d;
    logic [2:0]  n1_s;
    logic [14:0] n1_q14;
    logic        n1_note;
    logic        n1_clear;

    // Stage 2
    logic [PAL_AW-1:0] r2_sa;
    logic [PAL_AW-1:0] r2_sb;
    logic              r2_inrange;
    logic [3:0]        r2_k;
    logic [7:0]        r2_bright;
    logic              r2_clear;
    logic [PAL_AW-1:0] n2_sb;
    logic [6:0]        n2_q14x;
    logic [30:0]       n2_bq;
    logic [8:0]        n2_bsum;
    logic [7:0]        n2_bright;
    logic [23:0]       ram_a;
    logic [23:0]       ram_b;
    logic [23:0]       col_a;
    logic [23:0]       col_b;

    // Stages 3 to 6
    logic [7:0] r3_bright;
    logic [7:0] r4_bright;
    logic       r3_clear;
    logic       r4_clear;
    logic       r5_clear;
    logic       r6_clear;

    t_chan_ctl  chan_ctl;
    logic [7:0] lvl_r;
    logic [7:0] lvl_g;
    logic [7:0] lvl_b;

    // Ready chain from the output back to the input
    always_comb begin
        rdy[NSTG] = !r_v[NSTG] || !i_stall;
        for (int i = NSTG - 1; i >= 1; i--) begin
            rdy[i] = !r_v[i] || rdy[i+1];
        end
    end

    assign o_stall = !rdy[1];
    assign o_valid = r_v[NSTG];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_valid && n1_note;
            end
            for (int i = 2; i <= NSTG; i++) begin
                if (rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Configuration registers; palette lives in the RAM with per-entry written flags
    assign pal_we    = i_cfg_wr_en && (i_cfg_index != CFG_MIN_BRIGHT);
    assign pal_waddr = PAL_AW'(i_cfg_index - CFG_PAL_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bright <= MIN_BRIGHT_RESET;
            r_pal_wr     <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_MIN_BRIGHT) begin
                r_min_bright <= i_cfg_wdata[7:0];
            end else begin
                r_pal_wr[pal_waddr] <= 1'b1;
            end
        end
    end

    // Stage 1: decode, segment, d/14, velocity product
    assign n1_note  = (i_data.code_index == CODE_NOTE_ON) ||
                      (i_data.code_index == CODE_NOTE_OFF);
    assign n1_clear = (i_data.code_index == CODE_NOTE_OFF) || (i_data.note_velocity == 7'd0);
    assign n1_d     = i_data.note_number - NOTE_LOW;
    assign n1_s     = 3'(n1_d >= SEG_B1) + 3'(n1_d >= SEG_B2) + 3'(n1_d >= SEG_B3) +
                      3'(n1_d >= SEG_B4) + 3'(n1_d >= SEG_B5) + 3'(n1_d >= SEG_B6);
    assign n1_q14   = 15'(n1_d) * 15'(RECIP_14);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_d       <= n1_d;
            r1_s       <= n1_s;
            r1_q14     <= n1_q14[13:11];
            r1_bprod   <= 15'(i_data.note_velocity) * 15'(8'd255 - r_min_bright);
            r1_clear   <= n1_clear;
            r1_inrange <= (i_data.note_number >= NOTE_LOW) &&
                          (i_data.note_number <= NOTE_HIGH);
        end
    end

    // Stage 2: palette read, fraction, brightness
    assign n2_sb   = (r1_s == PAL_LAST) ? '0 : r1_s + 3'd1;
    assign n2_q14x = 7'({r1_q14, 4'b0}) - 7'({r1_q14, 1'b0});
    assign n2_bq   = 31'(r1_bprod) * 31'(RECIP_127);
    assign n2_bsum = {1'b0, n2_bq[29:22]} + {1'b0, r_min_bright};

    always_comb begin
        if (r1_clear) begin
            n2_bright = 8'd0;
        end else if (n2_bsum[8]) begin
            n2_bright = 8'd255;
        end else begin
            n2_bright = n2_bsum[7:0];
        end
    end

    mnlc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal (
        .i_clk     (i_clk),
        .i_we      (pal_we),
        .i_waddr   (pal_waddr),
        .i_wdata   (i_cfg_wdata),
        .i_re      (rdy[2]),
        .i_raddr_a (r1_s),
        .i_raddr_b (n2_sb),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_sa      <= r1_s;
            r2_sb      <= n2_sb;
            r2_inrange <= r1_inrange;
            r2_k       <= 4'(r1_d - n2_q14x);
            r2_bright  <= n2_bright;
            r2_clear   <= r1_clear;
        end
    end

    // Unwritten entries read as their defaults; notes out of range are black
    always_comb begin
        if (!r2_inrange) begin
            col_a = '0;
            col_b = '0;
        end else begin
            col_a = r_pal_wr[r2_sa] ? ram_a : PAL_RESET[r2_sa];
            col_b = r_pal_wr[r2_sb] ? ram_b : PAL_RESET[r2_sb];
        end
    end

    // Side band for stages 3 to 6
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_bright <= r2_bright;
            r3_clear  <= r2_clear;
        end
        if (rdy[4]) begin
            r4_bright <= r3_bright;
            r4_clear  <= r3_clear;
        end
        if (rdy[5]) begin
            r5_clear <= r4_clear;
        end
        if (rdy[6]) begin
            r6_clear <= r5_clear;
        end
    end

    // Per-channel blend and scale
    assign chan_ctl.ld_mix   = rdy[3];
    assign chan_ctl.ld_div   = rdy[4];
    assign chan_ctl.ld_scale = rdy[5];
    assign chan_ctl.ld_out   = rdy[6];

    mnlc_chan u_red (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_a      (col_a[23:16]),
        .i_b      (col_b[23:16]),
        .i_k      (r2_k),
        .i_bright (r4_bright),
        .o_level  (lvl_r)
    );

    mnlc_chan u_green (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_a      (col_a[15:8]),
        .i_b      (col_b[15:8]),
        .i_k      (r2_k),
        .i_bright (r4_bright),
        .o_level  (lvl_g)
    );

    mnlc_chan u_blue (
        .i_clk    (i_clk),
        .i_ctl    (chan_ctl),
        .i_a      (col_a[7:0]),
        .i_b      (col_b[7:0]),
        .i_k      (r2_k),
        .i_bright (r4_bright),
        .o_level  (lvl_b)
    );

    // Output beat
    assign o_data.led_action  = r6_clear;
    assign o_data.red_level   = lvl_r;
    assign o_data.green_level = lvl_g;
    assign o_data.blue_level  = lvl_b;

    // Checks
    a_off_enters_as_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.code_index == CODE_NOTE_OFF) |=> (r_v[1] && r1_clear))
        else $error("note-off beat did not enter stage 1 as a clear");

    a_other_code_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.code_index != CODE_NOTE_ON &&
         i_data.code_index != CODE_NOTE_OFF) |=> !r_v[1])
        else $error("non-note beat entered the pipeline");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v == '1 && i_stall))
        else $error("input stalled while the pipeline had room");

    a_clear_is_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.led_action) |->
        (o_data.red_level == 8'd0 && o_data.green_level == 8'd0 && o_data.blue_level == 8'd0))
        else $error("clear beat carries nonzero levels");

endmodule

@@ tb/midi_note_to_led_color_test.sv @@
module midi_note_to_led_color_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mnlc_pkg::*;

    // Result action codes
    localparam logic LED_SET   = 1'b0;
    localparam logic LED_CLEAR = 1'b1;

    // Code indexes that the block must ignore
    localparam logic [3:0] CODE_RESERVED      = 4'h0;
    localparam logic [3:0] CODE_SYSEX_END     = 4'h7;
    localparam logic [3:0] CODE_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] CODE_SINGLE_BYTE   = 4'hF;

    localparam int SETTLE_CYCLES  = 12;    // pipeline is 6 deep
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 19;

    typedef logic [PAL_DEPTH-1:0][COLOR_W-1:0] t_palette;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    t_in        i_data      = '0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    t_out       o_data;
    logic       i_cfg_wr_en = 1'b0;
    t_cfg_idx   i_cfg_index = CFG_MIN_BRIGHT;
    logic [23:0] i_cfg_wdata = '0;

    // Local copy of the configuration
    logic [7:0] min_bright_cfg = MIN_BRIGHT_RESET;
    t_palette   palette_cfg    = PAL_RESET;

    t_out led_expected[$];
    t_out led_want;
    int   fail_count  = 0;
    int   gap_pct     = IDLE_PCT;
    int   stall_pct   = IDLE_PCT;
    int   hold_left   = 0;
    int   quiet_count = 0;

    midi_note_to_led_color dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // LED command for one note event under the current configuration
    function automatic t_out led_for_event(input t_in ev);
        t_out        res;
        int unsigned d, seg, frac, vel, minb, bright, a_byte, b_byte;
        logic [23:0] ca, cb, mixed, lvl;
        res = '0;
        if (ev.code_index == CODE_NOTE_OFF || ev.note_velocity == 0) begin
            res.led_action = LED_CLEAR;
            return res;
        end
        mixed = '0;
        if (ev.note_number >= NOTE_LOW && ev.note_number <= NOTE_HIGH) begin
            d    = ev.note_number - NOTE_LOW;
            seg  = (d * 6) / 87;
            if (seg > PAL_DEPTH - 1)
                seg = PAL_DEPTH - 1;
            frac = d % 14;
            ca   = palette_cfg[seg];
            cb   = palette_cfg[(seg + 1) % PAL_DEPTH];
            for (int ch = 0; ch < 3; ch++) begin
                a_byte = ca[8*ch +: 8];
                b_byte = cb[8*ch +: 8];
                mixed[8*ch +: 8] = 8'((a_byte * (14 - frac) + b_byte * frac) / 14);
            end
        end
        vel    = ev.note_velocity;
        minb   = min_bright_cfg;
        bright = vel * (255 - minb) / 127 + minb;
        if (bright > 255)
            bright = 255;
        for (int ch = 0; ch < 3; ch++) begin
            a_byte = mixed[8*ch +: 8];
            lvl[8*ch +: 8] = 8'((a_byte * bright) / 255);
        end
        res.led_action  = LED_SET;
        res.red_level   = lvl[23:16];
        res.green_level = lvl[15:8];
        res.blue_level  = lvl[7:0];
        return res;
    endfunction

    // Mostly note-on/off with random content, a share of other codes
    function automatic t_in random_event();
        t_in         ev;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            ev.code_index = CODE_NOTE_ON;
        else if (pick < 85)
            ev.code_index = CODE_NOTE_OFF;
        else
            ev.code_index = 4'($urandom_range(15));
        if ($urandom_range(4) == 0)
            ev.note_number = 7'($urandom_range(127));
        else
            ev.note_number = 7'($urandom_range(NOTE_HIGH, NOTE_LOW));
        pick = $urandom_range(19);
        case (pick)
            0:       ev.note_velocity = 7'd0;
            1:       ev.note_velocity = 7'd127;
            2:       ev.note_velocity = 7'd1;
            default: ev.note_velocity = 7'($urandom_range(127));
        endcase
        return ev;
    endfunction

    function automatic t_palette random_palette();
        t_palette colors;
        for (int j = 0; j < PAL_DEPTH; j++)
            colors[j] = 24'($urandom());
        return colors;
    endfunction

    // Offer one beat, hold it until taken, then queue its expected result if it is a note beat
    task automatic send_event(input t_in ev);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= ev;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (ev.code_index == CODE_NOTE_ON || ev.code_index == CODE_NOTE_OFF)
            led_expected.push_back(led_for_event(ev));
    endtask

    // Stop sending and wait until every result is back and the pipe is empty
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (led_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight registers back to back while idle
    task automatic apply_config(input logic [23:0] min_word, input t_palette colors);
        drain_pipeline();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MIN_BRIGHT;
        i_cfg_wdata <= min_word;
        @(posedge i_clk);
        min_bright_cfg = min_word[7:0];
        for (int j = 0; j < PAL_DEPTH; j++) begin
            i_cfg_index <= t_cfg_idx'(CFG_PAL_0 + j);
            i_cfg_wdata <= colors[j];
            @(posedge i_clk);
            palette_cfg[j] = colors[j];
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_event(random_event());
    endtask

    // Field extremes, segment edges, out-of-range notes, clears, ignored codes
    task automatic test_directed();
        send_event(t_in'{CODE_NOTE_ON,  7'd0,   7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd20,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd21,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd34,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd35,  7'd100});
        send_event(t_in'{CODE_NOTE_ON,  7'd36,  7'd64});
        send_event(t_in'{CODE_NOTE_ON,  7'd49,  7'd1});
        send_event(t_in'{CODE_NOTE_ON,  7'd50,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd65,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd79,  7'd85});
        send_event(t_in'{CODE_NOTE_ON,  7'd94,  7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd107, 7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd108, 7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd109, 7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd127, 7'd127});
        send_event(t_in'{CODE_NOTE_ON,  7'd60,  7'd0});
        send_event(t_in'{CODE_NOTE_OFF, 7'd60,  7'd127});
        send_event(t_in'{CODE_NOTE_OFF, 7'd0,   7'd0});
        send_event(t_in'{CODE_NOTE_OFF, 7'd127, 7'd127});
        send_event(t_in'{CODE_RESERVED, 7'd127, 7'd127});
        send_event(t_in'{CODE_SINGLE_BYTE, 7'd60, 7'd60});
        send_event(t_in'{CODE_SYSEX_END, 7'd0, 7'd0});
        send_event(t_in'{CODE_POLY_PRESSURE, 7'd64, 7'd100});
        send_event(t_in'{CODE_NOTE_ON,  7'd64,  7'd127});
    endtask

    // Brightness floor at both ends, wide writes, white and black palettes
    task automatic test_config_extremes();
        apply_config(24'hFFFF00, {PAL_DEPTH{24'hFFFFFF}});
        send_random(40);
        apply_config(24'h0000FF, {PAL_DEPTH{24'hFFFFFF}});
        send_random(40);
        apply_config(24'h123480, '0);
        send_random(40);
        apply_config(24'($urandom()), random_palette());
        send_random(40);
    endtask

    // Bulk random traffic over several settings, one round with no idling
    task automatic test_random_traffic();
        for (int round = 0; round < 6; round++) begin
            if (round == 0)
                apply_config({16'h0000, MIN_BRIGHT_RESET}, PAL_RESET);
            else
                apply_config(24'($urandom()), random_palette());
            if (round == 2) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            send_random(140);
            gap_pct   = IDLE_PCT;
            stall_pct = IDLE_PCT;
        end
    endtask

    // Long receiver hold while the sender keeps pushing: the pipe must fill
    task automatic test_backpressure();
        drain_pipeline();
        hold_left = HOLD_CYCLES;
        gap_pct   = 0;
        for (int n = 0; n < 60; n++)
            send_event(t_in'{CODE_NOTE_ON, 7'($urandom_range(127)), 7'($urandom_range(127))});
        gap_pct = IDLE_PCT;
        drain_pipeline();
    endtask

    // Receiver stall: long hold on request, otherwise random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (led_expected.size() == 0) begin
                $display("%0t: unexpected result beat, got %h", $time, o_data);
                fail_count++;
            end else begin
                led_want = led_expected.pop_front();
                if (o_data.led_action !== led_want.led_action) begin
                    $display("%0t: led_action expected %0d got %0d",
                             $time, led_want.led_action, o_data.led_action);
                    fail_count++;
                end
                if (o_data.red_level !== led_want.red_level) begin
                    $display("%0t: red_level expected %0d got %0d",
                             $time, led_want.red_level, o_data.red_level);
                    fail_count++;
                end
                if (o_data.green_level !== led_want.green_level) begin
                    $display("%0t: green_level expected %0d got %0d",
                             $time, led_want.green_level, o_data.green_level);
                    fail_count++;
                end
                if (o_data.blue_level !== led_want.blue_level) begin
                    $display("%0t: blue_level expected %0d got %0d",
                             $time, led_want.blue_level, o_data.blue_level);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_count = 0;
        else
            quiet_count = quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("midi_note_to_led_color test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain_pipeline();

        if (fail_count == 0)
            $display("midi_note_to_led_color test passed");
        else
            $display("midi_note_to_led_color test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mnlc_pkg.sv
hdl/mnlc_ram.sv
hdl/mnlc_chan.sv
hdl/midi_note_to_led_color.sv
tb/midi_note_to_led_color_test.sv
